>>> rtl/rrip_pkg.sv
// Package for the RRIP replacement unit: shared types and fixed constants.
// No dependencies.
`timescale 1ns / 1ps
package rrip_pkg;
  // Cache geometry and policy sizes.
  localparam int NUM_SETS = 2048;
  localparam int NUM_WAYS = 16;
  localparam int LEADER_SETS = 64;
  localparam int SIGNATURE_BITS = 5;

  // Request commands.
  localparam logic CMD_VICTIM = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  localparam logic [1:0] RRPV_MAX = 2'd3;
  localparam logic [1:0] RRPV_LONG = 2'd2;
  localparam logic [1:0] RRPV_NEAR = 2'd0;
  localparam logic [9:0] SEL_MAX = 10'd1023;
  localparam logic [9:0] SEL_MID = 10'd512;
  localparam logic [4:0] SET_HASH_MASK = 5'h1F;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;    // clear one set of the memories
    logic latch;    // capture the request
    logic read;     // read the addressed set
    logic victim;   // run the victim search and write back
    logic upd;      // run the update and write back
  } dp_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic clear_done;
    logic is_update;
  } dp_stat_t;
endpackage

>>> rtl/rrip_replacement_with_stream_bypass_unit.sv
// Top level of the RRIP replacement unit with stream bypass.
// A victim request is read in S_READ and searched in S_EXEC; its result is then registered.
// Busy is high through the read-modify-write of the set memories; no request is taken then.
// Reset: synchronous, active low; then a pass clearing all NUM_SETS sets runs with busy high.
// The receiver cannot stall: out_valid marks a result for one cycle.
// Depends on rrip_pkg, rrip_ctrl and rrip_dp.
`timescale 1ns / 1ps
module rrip_replacement_with_stream_bypass_unit import rrip_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [10:0] in_set_index,
  input  logic [3:0]  in_way,
  input  logic [63:0] in_paddr,
  input  logic [6:0]  in_pc_low,
  input  logic        in_hit,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  output logic        out_valid,
  output logic [3:0]  out_victim_way
);
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [1:0] thr_r;

  // Streaming threshold register.
  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= 2'd2;
    else if (cfg_we) thr_r <= cfg_wdata;
  end

  rrip_ctrl u_ctrl (.clk, .rst_n, .start, .busy, .cmd, .stat);

  rrip_dp u_dp (
    .clk, .rst_n, .cmd, .stat, .in_cmd, .in_set_index, .in_way, .in_paddr,
    .in_pc_low, .in_hit, .cfg_threshold(thr_r), .out_valid, .out_victim_way);
endmodule

>>> rtl/rrip_ctrl.sv
// Controller state machine of the RRIP unit.
// Depends on rrip_pkg.
`timescale 1ns / 1ps
module rrip_ctrl import rrip_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);
  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_EXEC  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.latch = start;
        if (start) state_nxt = S_READ;
      end
      S_READ: begin
        cmd.read = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.victim = !stat.is_update;
        cmd.upd = stat.is_update;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else state_r <= state_nxt;
  end
endmodule

>>> rtl/rrip_dp.sv
// Datapath of the RRIP unit: set memories, detector, table and selector.
// Depends on rrip_pkg.
`timescale 1ns / 1ps
module rrip_dp import rrip_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic        in_cmd,
  input  logic [10:0] in_set_index,
  input  logic [3:0]  in_way,
  input  logic [63:0] in_paddr,
  input  logic [6:0]  in_pc_low,
  input  logic        in_hit,
  input  logic [1:0]  cfg_threshold,
  output logic        out_valid,
  output logic [3:0]  out_victim_way
);
  localparam int SW = $clog2(NUM_SETS);
  localparam int WW = $clog2(NUM_WAYS);
  localparam int SIGN = 1 << SIGNATURE_BITS;
  localparam int SB = SIGNATURE_BITS;

  // Per-set rows: one word holds all ways.
  logic [NUM_WAYS*2-1:0]  rrpv_mem [NUM_SETS];
  logic [NUM_WAYS*SB-1:0] sig_mem  [NUM_SETS];
  logic [129:0]           strd_mem [NUM_SETS];

  logic [NUM_WAYS*2-1:0]  rrpv_q;
  logic [NUM_WAYS*SB-1:0] sig_q;
  logic [129:0]           strd_q;

  logic        cmd_r, hit_r, ok_r;
  logic [10:0] set_r;
  logic [3:0]  way_r;
  logic [63:0] paddr_r;
  logic [6:0]  pc_r;
  logic [SW-1:0] clr_r;

  logic [1:0] outc_r [SIGN];
  logic [9:0] sel_r;
  logic [4:0] lcnt_r, fcnt_r;
  logic       valid_r;
  logic [3:0] vway_r;

  // Request capture; range checks happen here.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r <= in_cmd;
      set_r <= in_set_index;
      way_r <= in_way;
      paddr_r <= in_paddr;
      pc_r <= in_pc_low;
      hit_r <= in_hit;
      ok_r <= (32'(in_set_index) < NUM_SETS) &&
              (in_cmd == CMD_VICTIM || (32'(in_way) < NUM_WAYS));
    end
  end

  assign stat.is_update = (cmd_r == CMD_UPDATE);
  assign stat.clear_done = (32'(clr_r) == NUM_SETS - 1);

  // Victim search: age to the maximum and pick the lowest way at 3.
  logic [1:0] top;
  logic [1:0] add;
  logic [NUM_WAYS*2-1:0] aged;
  logic [WW-1:0] vsel;
  always_comb begin
    top = '0;
    for (int w = 0; w < NUM_WAYS; w++)
      if (rrpv_q[w*2 +: 2] > top) top = rrpv_q[w*2 +: 2];
    add = RRPV_MAX - top;
    vsel = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      aged[w*2 +: 2] = rrpv_q[w*2 +: 2] + add;
      if (aged[w*2 +: 2] == RRPV_MAX) vsel = WW'(w);
    end
  end

  // Update logic: stride detector, selector, signature table, insertion.
  logic [63:0] last, prev_stride, stride;
  logic [1:0]  mcnt, mcnt_new;
  logic        leader, bip_leader, streaming, hot, use_bip;
  logic [SB-1:0] sig, blk_sig;
  logic [WW-1:0] wsel;
  logic [4:0]  bip_cnt;
  logic [1:0]  ins;
  always_comb begin
    wsel = way_r[WW-1:0];
    last = strd_q[63:0];
    prev_stride = strd_q[127:64];
    mcnt = strd_q[129:128];
    stride = (last == 64'd0) ? 64'd0 : paddr_r - last;
    if (last != 64'd0 && stride == prev_stride && stride != 64'd0)
      mcnt_new = (mcnt == 2'd3) ? mcnt : mcnt + 2'd1;
    else
      mcnt_new = (mcnt == 2'd0) ? mcnt : mcnt - 2'd1;
    leader = 32'(set_r) < 2 * LEADER_SETS;
    bip_leader = leader && (32'(set_r) >= LEADER_SETS);
    sig = SB'({6'd0, pc_r[6:2] ^ (set_r[4:0] & SET_HASH_MASK)});
    blk_sig = sig_q[wsel*SB +: SB];
    streaming = mcnt_new >= cfg_threshold;
    hot = outc_r[sig] >= 2'd2;
    use_bip = leader ? bip_leader : (sel_r >= SEL_MID);
    bip_cnt = (bip_leader ? lcnt_r : fcnt_r) + 5'd1;
    if (streaming) ins = RRPV_MAX;
    else if (use_bip) ins = (bip_cnt == 5'd0) ? RRPV_NEAR : RRPV_LONG;
    else ins = hot ? RRPV_NEAR : RRPV_LONG;
  end

  // Set memories: clear sweep, read, write back.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        rrpv_mem[clr_r][w*2 +: 2] <= RRPV_LONG;
      end
      sig_mem[clr_r] <= '0;
      strd_mem[clr_r] <= '0;
    end
    if (cmd.read) begin
      rrpv_q <= rrpv_mem[set_r[SW-1:0]];
      sig_q  <= sig_mem[set_r[SW-1:0]];
      strd_q <= strd_mem[set_r[SW-1:0]];
    end
    if (cmd.victim && ok_r) rrpv_mem[set_r[SW-1:0]] <= aged;
    if (cmd.upd && ok_r) begin
      strd_mem[set_r[SW-1:0]] <= {mcnt_new, stride, paddr_r};
      rrpv_mem[set_r[SW-1:0]][wsel*2 +: 2] <= hit_r ? RRPV_NEAR : ins;
      if (!hit_r) sig_mem[set_r[SW-1:0]][wsel*SB +: SB] <= sig;
    end
  end

  // Global state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      sel_r <= SEL_MID;
      lcnt_r <= '0;
      fcnt_r <= '0;
      valid_r <= 1'b0;
      for (int i = 0; i < SIGN; i++) outc_r[i] <= 2'd1;
    end else begin
      valid_r <= cmd.victim;
      if (cmd.victim) vway_r <= ok_r ? 4'(vsel) : 4'd0;
      if (cmd.clear) clr_r <= clr_r + SW'(1);
      if (cmd.upd && ok_r) begin
        if (leader && hit_r) begin
          if (bip_leader) begin
            if (sel_r != SEL_MAX) sel_r <= sel_r + 10'd1;
          end else if (sel_r != 10'd0) sel_r <= sel_r - 10'd1;
        end
        if (hit_r) begin
          if (outc_r[blk_sig] != 2'd3) outc_r[blk_sig] <= outc_r[blk_sig] + 2'd1;
        end else begin
          if (outc_r[blk_sig] != 2'd0) outc_r[blk_sig] <= outc_r[blk_sig] - 2'd1;
          if (!streaming && use_bip) begin
            if (bip_leader) lcnt_r <= bip_cnt;
            else fcnt_r <= bip_cnt;
          end
        end
      end
    end
  end

  assign out_valid = valid_r;
  assign out_victim_way = vway_r;
endmodule

>>> rtl/rrip_checker.sv
// Port checker for the RRIP replacement unit, bound to the top level.
// Depends on the top level's ports only.
`timescale 1ns / 1ps
module rrip_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [3:0] out_victim_way
);
  // A request raises busy at the next edge.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised");
  // Results never come in two adjacent cycles.
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back to back results");
  // A result follows only a request taken while idle.
  a_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3)) else $error("result without request");
  // A victim way is always a known value.
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_victim_way)) else $error("unknown victim way");
endmodule

bind rrip_replacement_with_stream_bypass_unit rrip_checker u_chk (.clk, .rst_n, .start,
  .busy, .out_valid, .out_victim_way);

>>> verif/rrip_replacement_with_stream_bypass_unit_test.sv
// Self-checking testbench for the RRIP replacement unit with stream bypass.
// Drives victim and update requests, predicts every victim way and checks it.
// Depends on rrip_pkg and rrip_replacement_with_stream_bypass_unit.
`timescale 1ns / 1ps
module rrip_replacement_with_stream_bypass_unit_test;
  import rrip_pkg::*;

  localparam int NSETS = 2048;
  localparam int NWAYS = 16;
  localparam int NLEAD = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_cmd = CMD_VICTIM;
  logic [10:0] in_set_index = '0;
  logic [3:0] in_way = '0;
  logic [63:0] in_paddr = '0;
  logic [6:0] in_pc_low = '0;
  logic in_hit = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_wdata = '0;
  logic out_valid;
  logic [3:0] out_victim_way;

  int error_count = 0;
  int victim_count = 0;
  int update_count = 0;

  rrip_replacement_with_stream_bypass_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_set_index(in_set_index), .in_way(in_way),
    .in_paddr(in_paddr), .in_pc_low(in_pc_low), .in_hit(in_hit),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_victim_way(out_victim_way)
  );

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Replacement predictor plus the queue of victim ways still to arrive.
  class rrip_scoreboard;
    logic [1:0] rrpv [NSETS*NWAYS];
    logic [4:0] blk_sig [NSETS*NWAYS];
    logic [63:0] prev_addr_m [NSETS];
    logic [63:0] prev_stride_m [NSETS];
    logic [1:0] mono [NSETS];
    logic [1:0] outcome_tbl [32];
    logic [9:0] psel;
    logic [4:0] lead_ctr;
    logic [4:0] foll_ctr;
    logic [1:0] threshold;
    logic [3:0] victim_q [$];
    logic [3:0] last_victim;

    function new();
      foreach (rrpv[i]) rrpv[i] = RRPV_LONG;
      foreach (blk_sig[i]) blk_sig[i] = '0;
      foreach (prev_addr_m[i]) begin
        prev_addr_m[i] = '0;
        prev_stride_m[i] = '0;
        mono[i] = '0;
      end
      foreach (outcome_tbl[i]) outcome_tbl[i] = 2'd1;
      psel = SEL_MID;
      lead_ctr = '0;
      foll_ctr = '0;
      threshold = 2'd2;
      last_victim = '0;
    endfunction

    function int pending();
      return victim_q.size();
    endfunction

    // One BIP insertion step: near once per counter wrap, long otherwise.
    function logic [1:0] bip_step(ref logic [4:0] ctr);
      ctr = ctr + 5'd1;
      return (ctr == 5'd0) ? RRPV_NEAR : RRPV_LONG;
    endfunction

    // Age the set until some way reaches the maximum value; lowest such way wins.
    function logic [3:0] pick_victim(int set);
      logic [1:0] top;
      logic [1:0] add;
      int base;
      top = '0;
      base = set * NWAYS;
      for (int w = 0; w < NWAYS; w++) if (rrpv[base+w] > top) top = rrpv[base+w];
      add = RRPV_MAX - top;
      for (int w = 0; w < NWAYS; w++) rrpv[base+w] = rrpv[base+w] + add;
      for (int w = 0; w < NWAYS; w++) if (rrpv[base+w] == RRPV_MAX) return w[3:0];
      return '0;
    endfunction

    function void apply_update(int set, int way, logic [63:0] paddr, logic [6:0] pc,
                               logic hit);
      int blk;
      logic [63:0] stride;
      logic leader;
      logic bip_leader;
      logic streaming;
      logic hot;
      logic [4:0] sig;
      logic [4:0] old_sig;
      blk = set * NWAYS + way;
      stride = (prev_addr_m[set] == 0) ? 64'd0 : paddr - prev_addr_m[set];
      leader = set < 2 * NLEAD;
      bip_leader = leader && set >= NLEAD;
      if (prev_addr_m[set] != 0 && stride == prev_stride_m[set] && stride != 0) begin
        if (mono[set] < 2'd3) mono[set]++;
      end else if (mono[set] > 0) begin
        mono[set]--;
      end
      prev_addr_m[set] = paddr;
      prev_stride_m[set] = stride;
      sig = pc[6:2] ^ (set[4:0] & SET_HASH_MASK);
      if (leader && hit) begin
        if (bip_leader) begin
          if (psel < SEL_MAX) psel++;
        end else if (psel > 0) begin
          psel--;
        end
      end
      streaming = mono[set] >= threshold;
      // Hotness is taken before the victim signature is penalized.
      hot = outcome_tbl[sig] >= 2'd2;
      old_sig = blk_sig[blk];
      if (hit) begin
        if (outcome_tbl[old_sig] < 2'd3) outcome_tbl[old_sig]++;
        rrpv[blk] = RRPV_NEAR;
        return;
      end
      if (outcome_tbl[old_sig] > 0) outcome_tbl[old_sig]--;
      blk_sig[blk] = sig;
      if (streaming) rrpv[blk] = RRPV_MAX;
      else if (bip_leader) rrpv[blk] = bip_step(lead_ctr);
      else if (leader) rrpv[blk] = hot ? RRPV_NEAR : RRPV_LONG;
      else if (psel >= SEL_MID) rrpv[blk] = bip_step(foll_ctr);
      else rrpv[blk] = hot ? RRPV_NEAR : RRPV_LONG;
    endfunction

    function void note_request(logic cmd, logic [10:0] set, logic [3:0] way,
                               logic [63:0] paddr, logic [6:0] pc, logic hit);
      if (cmd == CMD_VICTIM) begin
        last_victim = pick_victim(set);
        victim_q.push_back(last_victim);
      end else begin
        apply_update(set, way, paddr, pc, hit);
      end
    endfunction

    task check_result(logic [3:0] got);
      logic [3:0] exp_way;
      if (victim_q.size() == 0) begin
        report_mismatch($sformatf("unexpected victim way %0d", got));
        return;
      end
      exp_way = victim_q.pop_front();
      if (got !== exp_way)
        report_mismatch($sformatf("victim way %0d, expected %0d", got, exp_way));
    endtask
  endclass

  rrip_scoreboard sb = new();

  initial begin
    forever #6 clk = ~clk;
  end

  // Monitor: check results first, then note the request accepted at this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_victim_way);
      if (start && !busy) begin
        sb.note_request(in_cmd, in_set_index, in_way, in_paddr, in_pc_low, in_hit);
        if (in_cmd == CMD_VICTIM) victim_count++;
        else update_count++;
      end
    end
  end

  // Present one request, hold it until accepted, then idle for a random gap.
  task automatic send_request(input logic cmd, input logic [10:0] set,
                              input logic [3:0] way, input logic [63:0] paddr,
                              input logic [6:0] pc, input logic hit, input bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    in_cmd = cmd;
    in_set_index = set;
    in_way = way;
    in_paddr = paddr;
    in_pc_low = pc;
    in_hit = hit;
    start = 1'b1;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drain, let trailing updates finish, then write the threshold.
  task automatic write_threshold(input logic [1:0] value);
    @(negedge clk);
    start = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
    wait (!busy);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.threshold = value;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Victim search and fill in that way, or a random-way hit, at a steady stride.
  task automatic stream_sequence(input logic [10:0] set, input int len);
    logic [63:0] addr;
    logic [63:0] stride;
    logic [6:0] pc;
    addr = rand64();
    stride = ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom_range(1, 256) * 64);
    pc = 7'($urandom_range(0, 127));
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 2) != 0) begin
        send_request(CMD_VICTIM, set, '0, addr, pc, 1'b0);
        // Let the monitor predict the victim before its way is used.
        @(negedge clk);
        send_request(CMD_UPDATE, set, sb.last_victim, addr, pc, 1'b0);
      end else begin
        send_request(CMD_UPDATE, set, 4'($urandom_range(0, 15)), addr, pc, 1'b1);
      end
      addr = addr + stride;
      if ($urandom_range(0, 3) == 0) pc = 7'($urandom_range(0, 127));
    end
  endtask

  function automatic logic [10:0] pick_set();
    case ($urandom_range(0, 3))
      0: return 11'($urandom_range(0, 63));
      1: return 11'($urandom_range(64, 127));
      2: return 11'($urandom_range(128, 143));
      default: return 11'($urandom_range(0, NSETS - 1));
    endcase
  endfunction

  initial begin
    int phase;
    logic [1:0] thresholds [4];
    thresholds = '{2'd1, 2'd3, 2'd0, 2'd2};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: field extremes, both commands, zero address, hit and fill.
    write_threshold(2'd3);
    send_request(CMD_VICTIM, 11'd0, 4'd0, 64'd0, 7'd0, 1'b0);
    send_request(CMD_VICTIM, 11'd2047, 4'd15, '1, 7'd127, 1'b1, 1);
    send_request(CMD_UPDATE, 11'd0, 4'd0, 64'd0, 7'd0, 1'b0, 1);
    send_request(CMD_UPDATE, 11'd0, 4'd15, '1, 7'd127, 1'b1);
    send_request(CMD_UPDATE, 11'd64, 4'd3, 64'h1000, 7'd8, 1'b1);
    send_request(CMD_UPDATE, 11'd127, 4'd0, 64'h2000, 7'd124, 1'b0);
    send_request(CMD_UPDATE, 11'd2047, 4'd15, 64'h8000_0000_0000_0000, 7'd64, 1'b0);
    send_request(CMD_VICTIM, 11'd2047, 4'd0, 64'd0, 7'd0, 1'b0);
    send_request(CMD_VICTIM, 11'd0, 4'd0, 64'd0, 7'd0, 1'b0);
    stream_sequence(11'd5, 8);
    stream_sequence(11'd70, 8);

    // Random: mostly strided victim-then-fill sequences, some noise.
    for (phase = 0; phase < 4; phase++) begin
      write_threshold(thresholds[phase]);
      while (victim_count + update_count < (phase + 1) * 235) begin
        if ($urandom_range(0, 4) != 0) begin
          int len;
          len = $urandom_range(2, 8);
          stream_sequence(pick_set(), len);
        end else begin
          send_request(1'($urandom_range(0, 1)), 11'($urandom_range(0, NSETS - 1)),
                       4'($urandom_range(0, 15)), rand64(), 7'($urandom_range(0, 127)),
                       1'($urandom_range(0, 1)));
        end
      end
    end

    @(negedge clk);
    start = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Covered %0d victim searches and %0d updates over four threshold settings.",
             victim_count, update_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches found", error_count);
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5ms;
    $display("Timed out with %0d victim ways outstanding", sb.pending());
    $display("FAILURE");
    $finish;
  end
endmodule

>>> files.f
rtl/rrip_pkg.sv
rtl/rrip_ctrl.sv
rtl/rrip_dp.sv
rtl/rrip_replacement_with_stream_bypass_unit.sv
rtl/rrip_checker.sv
verif/rrip_replacement_with_stream_bypass_unit_test.sv
